// ===== hw/rtl/mkda_pkg.sv =====
// mkda_pkg: constants, register codes and shared types for the multi-key
// debounce and auto-repeat block. No dependencies.
`default_nettype none

package mkda_pkg;

  // key count and field widths
  localparam int unsigned KEY_COUNT = 5;
  localparam int unsigned FIELD_W   = 5;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // keys that reach the 5-bit output fields
  localparam int unsigned OUT_KEYS  = (KEY_COUNT < FIELD_W) ? KEY_COUNT : FIELD_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_TOGGLE    = 2'd0,
    CFG_REPEAT_START  = 2'd1,
    CFG_REPEAT_PERIOD = 2'd2
  } cfg_idx_e;

  // register reset values
  localparam logic [CFG_W-1:0] MIN_TOGGLE_RST    = 16'd20;
  localparam logic [CFG_W-1:0] REPEAT_START_RST  = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 16'd100;

  // timing configuration seen by every lane
  typedef struct packed {
    logic [CFG_W-1:0] min_toggle;
    logic [CFG_W-1:0] repeat_start;
    logic [CFG_W-1:0] repeat_period;
  } cfg_t;

  // per-key result of one scan
  typedef struct packed {
    logic held;
    logic changed;
    logic repeated;
  } lane_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mkda_scan_if.sv =====
// mkda_scan_if: valid/ready channel carrying one key scan.
// Depends on mkda_pkg for field widths.
`default_nettype none

interface mkda_scan_if;
  logic                           valid;
  logic                           ready;
  logic [mkda_pkg::FIELD_W-1:0]   key_levels;
  logic [mkda_pkg::TIME_W-1:0]    now_time;

  modport source (output valid, output key_levels, output now_time, input ready);
  modport sink   (input valid, input key_levels, input now_time, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mkda_result_if.sv =====
// mkda_result_if: valid/ready channel carrying one debounce result.
// Depends on mkda_pkg for field widths.
`default_nettype none

interface mkda_result_if;
  logic                           valid;
  logic                           ready;
  logic [mkda_pkg::FIELD_W-1:0]   debounced_keys;
  logic [mkda_pkg::FIELD_W-1:0]   change_pulses;
  logic [mkda_pkg::FIELD_W-1:0]   repeat_pulses;

  modport source (output valid, output debounced_keys, output change_pulses,
                  output repeat_pulses, input ready);
  modport sink   (input valid, input debounced_keys, input change_pulses,
                  input repeat_pulses, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mkda_key_lane.sv =====
// mkda_key_lane: debounce and auto-repeat state of one key.
// Depends on mkda_pkg for widths and the cfg_t / lane_t types.
`default_nettype none

module mkda_key_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        scan_en_i,
  input  wire logic                        level_i,
  input  wire logic [mkda_pkg::TIME_W-1:0] now_i,
  input  wire mkda_pkg::cfg_t              cfg_i,
  output mkda_pkg::lane_t                  lane_o
);

  logic                        state_q, state_d;
  logic [mkda_pkg::TIME_W-1:0] change_q, change_d;
  logic [mkda_pkg::TIME_W-1:0] repeat_q, repeat_d;
  logic [mkda_pkg::TIME_W-1:0] since_change;
  logic [mkda_pkg::TIME_W-1:0] since_repeat;
  logic                        toggle_ok;
  logic                        start_ok;
  logic                        period_ok;
  logic                        do_change;
  logic                        do_repeat;

  // elapsed ticks, wrapping modulo 2^32
  assign since_change = now_i - change_q;
  assign since_repeat = now_i - repeat_q;

  assign toggle_ok = since_change >= {16'd0, cfg_i.min_toggle};
  assign start_ok  = since_change >= {16'd0, cfg_i.repeat_start};
  assign period_ok = since_repeat >= {16'd0, cfg_i.repeat_period};

  // a differing level changes state; a held pressed level may repeat
  assign do_change = (level_i != state_q) && toggle_ok;
  assign do_repeat = (level_i == state_q) && level_i && start_ok && period_ok;

  always_comb begin
    state_d  = state_q;
    change_d = change_q;
    repeat_d = repeat_q;
    if (do_change) begin
      state_d  = level_i;
      change_d = now_i;
    end
    if (do_repeat) begin
      repeat_d = now_i;
    end
  end

  assign lane_o.held     = state_d;
  assign lane_o.changed  = do_change;
  assign lane_o.repeated = do_repeat;

  // state advances on each scan transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= 1'b0;
      change_q <= '0;
      repeat_q <= '0;
    end else if (scan_en_i) begin
      state_q  <= state_d;
      change_q <= change_d;
      repeat_q <= repeat_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mkda_merge.sv =====
// mkda_merge: gathers the lane results into the output fields and holds
// them in the output register. Depends on mkda_pkg and mkda_result_if.
`default_nettype none

module mkda_merge (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   scan_valid_i,
  output logic                                        scan_ready_o,
  input  wire mkda_pkg::lane_t [mkda_pkg::KEY_COUNT-1:0] lanes_i,
  mkda_result_if.source                               result
);

  logic                         valid_q;
  logic [mkda_pkg::FIELD_W-1:0] held_q, held_d;
  logic [mkda_pkg::FIELD_W-1:0] chg_q, chg_d;
  logic [mkda_pkg::FIELD_W-1:0] rep_q, rep_d;
  logic                         load;

  // output register empties or drains this cycle
  assign scan_ready_o = !valid_q || result.ready;
  assign load         = scan_valid_i && scan_ready_o;

  // pack lane bits; keys past the field width are dropped
  always_comb begin
    held_d = '0;
    chg_d  = '0;
    rep_d  = '0;
    for (int unsigned k = 0; k < mkda_pkg::OUT_KEYS; k++) begin
      held_d[k] = lanes_i[k].held;
      chg_d[k]  = lanes_i[k].changed;
      rep_d[k]  = lanes_i[k].repeated;
    end
  end

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (scan_ready_o) begin
      valid_q <= scan_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      held_q <= held_d;
      chg_q  <= chg_d;
      rep_q  <= rep_d;
    end
  end

  assign result.valid          = valid_q;
  assign result.debounced_keys = held_q;
  assign result.change_pulses  = chg_q;
  assign result.repeat_pulses  = rep_q;

endmodule

`default_nettype wire

// ===== hw/rtl/multi_key_debounce_autorepeat.sv =====
// multi_key_debounce_autorepeat: top level with configuration registers,
// one lane per key and the merge stage. Depends on mkda_pkg, mkda_scan_if,
// mkda_result_if, mkda_key_lane and mkda_merge.
//
// Usage:
//   scan   : sink channel, one transfer per key scan (key_levels, now_time).
//   result : source channel, one transfer per scan (debounced_keys,
//            change_pulses, repeat_pulses).
//   cfg    : write port, cfg_idx_i selects min_toggle (0), repeat_start (1)
//            or repeat_period (2); other indexes are ignored. Write only
//            while no scan is in flight.
// Result valid follows in the cycle after scan transfer. Throughput is
// one scan per cycle unless stalled: all key lanes evaluate in parallel,
// each with two 32-bit subtract-and-compare paths, and the output
// register holds the merged result. When the receiver stalls, scan.ready
// drops while the output register is full and rises once it is taken.
// Reset clears all keys to released with zero time stamps and loads the
// register defaults (20, 500, 100 ticks); keys are not sampled.
`default_nettype none

module multi_key_debounce_autorepeat (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mkda_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mkda_pkg::CFG_W-1:0]     cfg_data_i,
  mkda_scan_if.sink                           scan,
  mkda_result_if.source                       result
);

  mkda_pkg::cfg_t                                cfg_q;
  mkda_pkg::lane_t [mkda_pkg::KEY_COUNT-1:0]     lanes;
  logic                                          scan_ready;
  logic                                          scan_en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_toggle    <= mkda_pkg::MIN_TOGGLE_RST;
      cfg_q.repeat_start  <= mkda_pkg::REPEAT_START_RST;
      cfg_q.repeat_period <= mkda_pkg::REPEAT_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mkda_pkg::CFG_MIN_TOGGLE:    cfg_q.min_toggle    <= cfg_data_i;
        mkda_pkg::CFG_REPEAT_START:  cfg_q.repeat_start  <= cfg_data_i;
        mkda_pkg::CFG_REPEAT_PERIOD: cfg_q.repeat_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign scan.ready = scan_ready;
  assign scan_en    = scan.valid && scan_ready;

  // one lane per key; keys past the field width see a released level
  for (genvar k = 0; k < mkda_pkg::KEY_COUNT; k++) begin : g_lane
    logic level;
    if (k < mkda_pkg::FIELD_W) begin : g_in
      assign level = scan.key_levels[k];
    end else begin : g_pad
      assign level = 1'b0;
    end

    mkda_key_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .scan_en_i (scan_en),
      .level_i   (level),
      .now_i     (scan.now_time),
      .cfg_i     (cfg_q),
      .lane_o    (lanes[k])
    );
  end

  // merge lanes into the output register
  mkda_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_valid_i (scan.valid),
    .scan_ready_o (scan_ready),
    .lanes_i      (lanes),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mkda_checker.sv =====
// mkda_checker: port-level assertions for multi_key_debounce_autorepeat,
// bound to the top level. Depends on mkda_pkg for field widths.
`default_nettype none

module mkda_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         scan_valid_i,
  input wire logic                         scan_ready_i,
  input wire logic                         res_valid_i,
  input wire logic                         res_ready_i,
  input wire logic [mkda_pkg::FIELD_W-1:0] res_held_i,
  input wire logic [mkda_pkg::FIELD_W-1:0] res_chg_i,
  input wire logic [mkda_pkg::FIELD_W-1:0] res_rep_i
);

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // every scan transfer yields a result on the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_valid_i && scan_ready_i |=> res_valid_i)
    else $error("no result one cycle after scan transfer");

  // repeats only come from keys held pressed
  a_rep_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_rep_i & ~res_held_i) == '0)
    else $error("repeat on a released key");

  // a key cannot change and repeat in the same scan
  a_rep_chg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_rep_i & res_chg_i) == '0)
    else $error("repeat and change on the same key");

endmodule

bind multi_key_debounce_autorepeat mkda_checker u_mkda_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .scan_valid_i (scan.valid),
  .scan_ready_i (scan.ready),
  .res_valid_i  (result.valid),
  .res_ready_i  (result.ready),
  .res_held_i   (result.debounced_keys),
  .res_chg_i    (result.change_pulses),
  .res_rep_i    (result.repeat_pulses)
);

`default_nettype wire
